### design/tmcw_pkg.sv
`timescale 1ns / 1ps

package tmcw_pkg;

    // fixed field widths of the stream payload
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;

    localparam int S_TDATA_W = 24;  // char, row, col = 20 bits, padded to bytes
    localparam int M_TDATA_W = 48;  // row, col, write value, read value = 44 bits
    localparam int M_TUSER_W = 2;

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] RETURN_CODE  = 8'd13;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_DISPATCH = 9'b000000100,
        ST_SCROLL   = 9'b000001000,
        ST_DRAIN    = 9'b000010000,
        ST_BLANK    = 9'b000100000,
        ST_PUT      = 9'b001000000,
        ST_READ     = 9'b010000000,
        ST_FIN      = 9'b100000000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic cnt_clr;
        logic cnt_inc;
        logic clr_wr;
        logic copy_rd;
        logic blank_wr;
        logic fin_scroll;
        logic do_put;
        logic do_read;
        logic load_out;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic copy_last;
        logic blank_last;
        logic need_scroll;
        logic is_read;
        logic out_free;
    } dp_status_t;

endpackage

### design/text_mode_console_writer.sv
`timescale 1ns / 1ps

// Teletype engine over a ROWS x COLS text-cell store (default 25 x 80), each
// cell 16 bits: attribute high byte, character low byte. Every input transaction
// yields exactly one result transaction. A put (s_tuser = 0) writes
// char_code with the current text attribute at the cursor, or handles
// newline (advance row, column 0) and carriage return (no effect); the
// cursor starts at row 1, column 0. When the cursor row has moved past the
// bottom row, the put first scrolls the whole screen up one row and blanks the
// last row. A read (s_tuser = 1) returns one cell, or 0 when out of range.
// Timing: after reset the store is cleared to blank cells, one cell per
// cycle, during which s_tready stays low; the attribute register may still
// be written then. A plain put or a read runs the controller states
// dispatch, put or read, and finish, which loads the result once the output
// register is free and returns to idle for the next transaction. A
// scrolling put first runs a copy pass, a drain state and a blank pass: the
// cell store moves one cell per cycle through its registered read, then
// blanks the bottom row one cell per cycle. One item is in flight at a time;
// the next is accepted while a result waits in the output register.
module text_mode_console_writer #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // attribute register
    input  logic                            cfg_wen,
    input  logic [tmcw_pkg::ATTR_W-1:0]     cfg_wdata,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tmcw_pkg::S_TDATA_W-1:0]  s_tdata,  // char_code[7:0], read_row[12:8],
                                                      // read_col[19:13], zero pad
    input  logic                            s_tuser,  // cmd
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tmcw_pkg::M_TDATA_W-1:0]  m_tdata,  // write_row[4:0], write_col[11:5],
                                                      // write_value[27:12],
                                                      // read_value[43:28], zero pad
    output logic [tmcw_pkg::M_TUSER_W-1:0]  m_tuser   // cell_written[0], scrolled[1]
);
    import tmcw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // input field split
    logic [CHAR_W-1:0] in_char;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;

    assign in_char = s_tdata[CHAR_W-1:0];
    assign in_row  = s_tdata[CHAR_W+ROW_W-1:CHAR_W];
    assign in_col  = s_tdata[CHAR_W+ROW_W+COL_W-1:CHAR_W+ROW_W];

    // sequencer: clear pass, dispatch, scroll copy/blank, put/read, finish
    tmcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // cursor, cell store, counters and the result register
    tmcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_tuser),
        .in_char   (in_char),
        .in_row    (in_row),
        .in_col    (in_col),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### design/tmcw_ctrl.sv
`timescale 1ns / 1ps

module tmcw_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  tmcw_pkg::dp_status_t  status,
    output tmcw_pkg::ctrl_cmd_t   cmd
);
    import tmcw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.clr_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.cnt_clr = 1'b1;
                if (status.is_read) begin
                    state_next = ST_READ;
                end else if (status.need_scroll) begin
                    state_next = ST_SCROLL;
                end else begin
                    state_next = ST_PUT;
                end
            end
            ST_SCROLL: begin
                cmd.copy_rd = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.copy_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last copied cell lands here
                state_next = ST_BLANK;
            end
            ST_BLANK: begin
                cmd.blank_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (status.blank_last) begin
                    cmd.cnt_clr    = 1'b1;
                    cmd.fin_scroll = 1'b1;
                    state_next     = ST_PUT;
                end
            end
            ST_PUT: begin
                cmd.do_put = 1'b1;
                state_next = ST_FIN;
            end
            ST_READ: begin
                cmd.do_read = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### design/tmcw_datapath.sv
`timescale 1ns / 1ps

module tmcw_datapath #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [tmcw_pkg::ATTR_W-1:0]     cfg_wdata,
    input  logic                            in_cmd,
    input  logic [tmcw_pkg::CHAR_W-1:0]     in_char,
    input  logic [tmcw_pkg::ROW_W-1:0]      in_row,
    input  logic [tmcw_pkg::COL_W-1:0]      in_col,
    input  tmcw_pkg::ctrl_cmd_t             cmd,
    output tmcw_pkg::dp_status_t            status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tmcw_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [tmcw_pkg::M_TUSER_W-1:0]  m_tuser
);
    import tmcw_pkg::*;

    localparam int CELLS   = ROWS * COLS;
    localparam int COPY_N  = (ROWS - 1) * COLS;
    localparam int AW      = $clog2(CELLS);
    localparam int RW      = $clog2(ROWS + 1);   // row may sit at ROWS awaiting a scroll
    localparam int CW      = $clog2(COLS);

    logic [CELL_W-1:0] mem [CELLS];

    logic [ATTR_W-1:0] attr_reg;
    logic [RW-1:0]     row_reg;
    logic [CW-1:0]     col_reg;
    logic [AW-1:0]     cnt_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic [CELL_W-1:0] rdata_reg;

    logic              is_read_reg;
    logic              in_range_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              scrolled_reg;

    logic              res_written_reg;
    logic [ROW_W-1:0]  res_row_reg;
    logic [COL_W-1:0]  res_col_reg;
    logic [CELL_W-1:0] res_value_reg;

    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    // put arithmetic
    logic [CW-1:0]     col_eff;
    logic [AW-1:0]     put_addr;
    logic [31:0]       col_inc;
    logic [31:0]       row_ext;
    logic [31:0]       col_ext;
    logic              is_nl;
    logic              is_cr;
    logic              put_store;
    logic [CELL_W-1:0] put_value;
    logic [RW-1:0]     row_next;
    logic [CW-1:0]     col_next;

    // memory ports
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic              out_free;
    logic              in_range;

    always_comb begin
        col_eff   = (32'(col_reg) >= COLS) ? '0 : col_reg;
        put_addr  = AW'(32'(row_reg) * COLS + 32'(col_eff));
        col_inc   = 32'(col_eff) + 32'd1;
        row_ext   = 32'(row_reg);
        col_ext   = 32'(col_eff);
        is_nl     = (char_reg == NEWLINE_CODE);
        is_cr     = (char_reg == RETURN_CODE);
        put_store = !is_nl && !is_cr;
        put_value = {attr_reg, char_reg};
        row_next  = row_reg;
        col_next  = col_reg;
        if (is_nl) begin
            row_next = RW'(32'(row_reg) + 32'd1);
            col_next = '0;
        end else if (!is_cr) begin
            if (col_inc == 32'(COLS)) begin
                row_next = RW'(32'(row_reg) + 32'd1);
                col_next = '0;
            end else begin
                col_next = CW'(col_inc);
            end
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = BLANK_CELL;
        if (pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = rdata_reg;
        end else if (cmd.clr_wr) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg;
        end else if (cmd.blank_wr) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(COPY_N) + cnt_reg;
        end else if (cmd.do_put && put_store) begin
            mem_we    = 1'b1;
            mem_waddr = put_addr;
            mem_wdata = put_value;
        end
        mem_re    = cmd.copy_rd || cmd.do_read;
        mem_raddr = cmd.copy_rd ? (cnt_reg + AW'(COLS)) : rd_addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg      <= ATTR_RESET;
            row_reg       <= RW'(1);
            col_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                attr_reg <= cfg_wdata;
            end
            if (cmd.fin_scroll) begin
                row_reg <= RW'(ROWS - 1);
            end else if (cmd.do_put) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            pend_reg <= cmd.copy_rd;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign in_range = (32'(in_row) < ROWS) && (32'(in_col) < COLS);

    // payload
    always_ff @(posedge aclk) begin
        pend_addr_reg <= cnt_reg;
        if (cmd.latch_in) begin
            is_read_reg  <= in_cmd;
            char_reg     <= in_char;
            in_range_reg <= in_range;
            rd_addr_reg  <= in_range ? AW'(32'(in_row) * COLS + 32'(in_col)) : '0;
            scrolled_reg <= 1'b0;
        end else if (cmd.fin_scroll) begin
            scrolled_reg <= 1'b1;
        end
        if (cmd.do_put) begin
            res_written_reg <= put_store;
            res_row_reg     <= put_store ? row_ext[ROW_W-1:0] : '0;
            res_col_reg     <= put_store ? col_ext[COL_W-1:0] : '0;
            res_value_reg   <= put_store ? put_value : '0;
        end else if (cmd.do_read) begin
            res_written_reg <= 1'b0;
            res_row_reg     <= '0;
            res_col_reg     <= '0;
            res_value_reg   <= '0;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {4'b0,
                            (is_read_reg && in_range_reg) ? rdata_reg : {CELL_W{1'b0}},
                            res_value_reg, res_col_reg, res_row_reg};
            m_tuser_reg <= {scrolled_reg, res_written_reg};
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    assign status.clr_last    = (cnt_reg == AW'(CELLS - 1));
    assign status.copy_last   = (cnt_reg == AW'(COPY_N - 1));
    assign status.blank_last  = (cnt_reg == AW'(COLS - 1));
    assign status.need_scroll = (32'(row_reg) >= ROWS);
    assign status.is_read     = is_read_reg;
    assign status.out_free    = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a pending copy write must never collide with another write source
    a_copy_write_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !(cmd.clr_wr || cmd.blank_wr || cmd.do_put))
        else $error("copy write collides with another write");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(row_reg) <= ROWS)
        else $error("cursor row beyond scroll point");

    a_put_below_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_put |-> (32'(row_reg) < ROWS))
        else $error("put issued without pending scroll done");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result overwritten before transfer");

endmodule

### bench/tb_text_mode_console_writer.sv
`timescale 1ns / 1ps

// Text console writer bench: a cycle-free model of the 25 x 80 cell store and
// cursor runs beside the block. Each accepted input transaction is pushed
// through the model straight away, and its predicted result waits in a queue.
// The result checker pops the oldest entry for each result transaction and
// compares it field by field.
module tb_text_mode_console_writer;
    import tmcw_pkg::*;

    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int CELLS = ROWS * COLS;

    // s_tuser codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Worst case per item is a scroll (a copy pass over the cell store) plus the
    // longest sender gap and receiver stall. Allow that for several times the
    // item count, on top of the clearing pass after reset.
    localparam longint CYCLE_LIMIT = 64'd6000 * (CELLS + 200);

    typedef struct packed {
        logic              cell_written;
        logic [ROW_W-1:0]  write_row;
        logic [COL_W-1:0]  write_col;
        logic [CELL_W-1:0] write_value;
        logic              scrolled;
        logic [CELL_W-1:0] read_value;
    } console_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [ATTR_W-1:0]     cfg_wdata = ATTR_RESET;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = CMD_PUT;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // Model of the screen and cursor
    logic [CELL_W-1:0]     screen_model [0:CELLS-1];
    int unsigned           cur_row;
    int unsigned           cur_col;
    logic [ATTR_W-1:0]     text_attr;

    console_result_t       pending_results [$];
    int                    fail_count = 0;
    longint                cycle_count = 0;

    // idling controls, switched per test
    bit                    gaps_on   = 1'b0;
    bit                    stalls_on = 1'b0;
    int                    stall_left = 0;

    text_mode_console_writer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    function automatic void reset_console_model();
        for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cur_row   = 1;
        cur_col   = 0;
        text_attr = ATTR_RESET;
    endfunction

    // Applies one item to the model and returns the result it should give.
    function automatic console_result_t console_step(logic cmd, logic [CHAR_W-1:0] ch,
                                                     logic [ROW_W-1:0] rr,
                                                     logic [COL_W-1:0] rc);
        console_result_t res;
        logic [CELL_W-1:0] cell_val;
        res = '0;
        if (cmd == CMD_READ) begin
            // out of range reads give zero; the state is left alone
            if (int'(rr) < ROWS && int'(rc) < COLS)
                res.read_value = screen_model[int'(rr) * COLS + int'(rc)];
            return res;
        end
        // the put scrolls first once the cursor has dropped off the bottom
        if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
            for (int i = 0; i < COLS; i++) screen_model[(ROWS - 1) * COLS + i] = BLANK_CELL;
            cur_row      = ROWS - 1;
            res.scrolled = 1'b1;
        end
        if (ch == NEWLINE_CODE) begin
            cur_col = 0;
            cur_row++;
        end else if (ch != RETURN_CODE) begin
            cell_val = {text_attr, ch};
            if (cur_col >= COLS) cur_col = 0;
            screen_model[cur_row * COLS + cur_col] = cell_val;
            res.cell_written = 1'b1;
            res.write_row    = cur_row[ROW_W-1:0];
            res.write_col    = cur_col[COL_W-1:0];
            res.write_value  = cell_val;
            cur_col++;
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
        end
        return res;
    endfunction

    // Mostly back to back, sometimes a short gap, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        else if (pick < 92) return $urandom_range(1, 3);
        else return $urandom_range(4, 40);
    endfunction

    function automatic int text_line_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(0, 40);
        else if (pick < 90) return $urandom_range(41, COLS - 1);
        else return $urandom_range(COLS, 2 * COLS + 10);   // wraps at least once
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // m_tdata pad bits are not checked
    always @(posedge aclk) begin : result_check
        console_result_t got;
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.write_row    = m_tdata[4:0];
            got.write_col    = m_tdata[11:5];
            got.write_value  = m_tdata[27:12];
            got.read_value   = m_tdata[43:28];
            got.cell_written = m_tuser[0];
            got.scrolled     = m_tuser[1];
            if (pending_results.size() == 0) begin
                $display("%0t: result transaction with nothing expected, tuser %h tdata %h",
                         $time, m_tuser, m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("cell_written", want.cell_written, got.cell_written);
                check_field("write_row", want.write_row, got.write_row);
                check_field("write_col", want.write_col, got.write_col);
                check_field("write_value", want.write_value, got.write_value);
                check_field("scrolled", want.scrolled, got.scrolled);
                check_field("read_value", want.read_value, got.read_value);
            end
        end
    end

    // Receiver back-pressure: random stalls of mixed length when enabled
    always @(posedge aclk) begin
        if (!stalls_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 20) begin
            m_tready   <= 1'b0;
            stall_left <= idle_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    // Offers one item, waits for the transaction, records its prediction,
    // then idles for a random gap if gaps are on. tvalid stays high when the
    // gap is zero, so the next call just replaces the payload.
    task automatic send_console_item(logic cmd, logic [CHAR_W-1:0] ch,
                                     logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, rc, rr, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(console_step(cmd, ch, rr, rc));
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sender holds off until every expected result is in, then waits for the
    // block to settle before any attribute write.
    task automatic drain_results();
        if (s_tvalid) s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        text_attr = value;
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Cleared store: corners and middle read blank, out of range reads give 0
    task automatic test_power_on_screen();
        send_console_item(CMD_READ, 8'hFF, 5'd0, 7'd0);
        send_console_item(CMD_READ, 8'h00, 5'd24, 7'd79);
        send_console_item(CMD_READ, 8'hA5, 5'd1, 7'd0);
        send_console_item(CMD_READ, 8'h5A, 5'd12, 7'd40);
        send_console_item(CMD_READ, 8'h00, 5'd25, 7'd0);
        send_console_item(CMD_READ, 8'h00, 5'd0, 7'd80);
        send_console_item(CMD_READ, 8'hFF, 5'd31, 7'd127);
        send_console_item(CMD_READ, 8'h00, 5'd24, 7'd127);
    endtask

    // Byte extremes, high bytes (no sign extension), carriage return ignored,
    // newline moves to the next row. Read fields on most puts are all ones.
    task automatic test_special_bytes();
        send_console_item(CMD_PUT, 8'h41, 5'h1F, 7'h7F);
        send_console_item(CMD_PUT, 8'h00, 5'h1F, 7'h7F);
        send_console_item(CMD_PUT, 8'hFF, 5'h1F, 7'h7F);
        send_console_item(CMD_PUT, 8'h80, 5'h1F, 7'h7F);
        send_console_item(CMD_PUT, RETURN_CODE, 5'h00, 7'h00);
        send_console_item(CMD_PUT, NEWLINE_CODE, 5'h1F, 7'h7F);
        send_console_item(CMD_PUT, 8'h42, 5'h00, 7'h00);
        send_console_item(CMD_READ, 8'h00, 5'd1, 7'd0);
        send_console_item(CMD_READ, 8'h00, 5'd1, 7'd3);
        send_console_item(CMD_READ, 8'h00, 5'd1, 7'd4);
        send_console_item(CMD_READ, 8'h00, 5'd2, 7'd0);
    endtask

    task automatic test_attribute_extremes();
        drain_results();
        write_attribute(8'hFF);
        send_console_item(CMD_PUT, 8'h78, 5'd0, 7'd0);
        drain_results();
        write_attribute(8'h00);
        send_console_item(CMD_PUT, 8'h79, 5'd0, 7'd0);
        send_console_item(CMD_READ, 8'h00, 5'd2, 7'd1);
        send_console_item(CMD_READ, 8'h00, 5'd2, 7'd2);
    endtask

    // Lines of text ending in newlines, long lines that wrap, which drive the
    // cursor to the bottom and keep the screen scrolling. Mixed in: reads near
    // the cursor, anywhere on screen and out of range, and puts of any byte.
    task automatic test_random_text(int n_items, logic [ATTR_W-1:0] attr, bit idle);
        int sent;
        int line_left;
        int pick;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        drain_results();
        write_attribute(attr);
        gaps_on   = idle;
        stalls_on = idle;
        sent      = 0;
        line_left = text_line_len();
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            ch   = CHAR_W'($urandom_range(0, 255));
            rr   = ROW_W'($urandom_range(0, 31));
            rc   = COL_W'($urandom_range(0, 127));
            if (pick < 15) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    rr = (cur_row >= ROWS) ? ROW_W'(ROWS - 1) : cur_row[ROW_W-1:0];
                    rc = COL_W'($urandom_range(0, COLS - 1));
                end else if (pick < 8) begin
                    rr = ROW_W'($urandom_range(0, ROWS - 1));
                    rc = COL_W'($urandom_range(0, COLS - 1));
                end
                send_console_item(CMD_READ, ch, rr, rc);
            end else if (pick < 20) begin
                send_console_item(CMD_PUT, ch, rr, rc);
            end else if (line_left == 0) begin
                send_console_item(CMD_PUT, NEWLINE_CODE, rr, rc);
                line_left = text_line_len();
            end else begin
                if ($urandom_range(0, 9) == 0) ch = CHAR_W'($urandom_range(128, 255));
                else ch = CHAR_W'($urandom_range(32, 126));
                send_console_item(CMD_PUT, ch, rr, rc);
                line_left--;
            end
            sent++;
        end
        drain_results();
    endtask

    initial begin
        reset_console_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_power_on_screen();
        test_special_bytes();
        test_attribute_extremes();
        test_random_text(520, ATTR_W'($urandom_range(0, 255)), 1'b1);
        test_random_text(320, 8'h00, 1'b0);
        test_random_text(380, 8'hFF, 1'b1);
        test_random_text(330, ATTR_RESET, 1'b1);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
